### design/imu_orientation_motion_classifier_unit_defines.svh
// Assertion macros for the IMU orientation and motion classifier unit.
`ifndef IMU_ORIENTATION_MOTION_CLASSIFIER_UNIT_DEFINES_SVH
`define IMU_ORIENTATION_MOTION_CLASSIFIER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define IMU_OMC_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Implication with a delayed consequent.
`define IMU_OMC_ASSERT_DLY3(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##3 (cons)) \
        else $error(msg);

`endif

### design/imu_omc_pkg.sv
// Package: widths, thresholds, codes and sensitivity tables of the IMU classifier.
`timescale 1ns / 1ps
package imu_omc_pkg;

    // Scaled axis value: 16-bit sample times 17-bit sensitivity, less a 25-bit offset
    localparam int VAL_W  = 34;
    localparam int SENS_W = 17;
    localparam int MAG_W  = 32;

    localparam logic signed [VAL_W-1:0] ACCEL_THRESH_UG  = 34'sd750000;
    localparam logic        [MAG_W-1:0] GYRO_THRESH_UDPS = 32'd10000000;

    // Commands
    localparam logic CMD_ACCEL = 1'b0;
    localparam logic CMD_GYRO  = 1'b1;

    // Configuration register indexes
    localparam logic [2:0] CFG_ACCEL_RANGE = 3'd0;
    localparam logic [2:0] CFG_GYRO_RANGE  = 3'd1;
    localparam logic [2:0] CFG_OFFSET_X    = 3'd2;
    localparam logic [2:0] CFG_OFFSET_Y    = 3'd3;
    localparam logic [2:0] CFG_OFFSET_Z    = 3'd4;

    // Orientation classes
    localparam logic [2:0] ORI_SCREEN_DOWN = 3'd0;
    localparam logic [2:0] ORI_SCREEN_UP   = 3'd1;
    localparam logic [2:0] ORI_TOP_DOWN    = 3'd2;
    localparam logic [2:0] ORI_BOTTOM_DOWN = 3'd3;
    localparam logic [2:0] ORI_RIGHT_DOWN  = 3'd4;
    localparam logic [2:0] ORI_LEFT_DOWN   = 3'd5;
    localparam logic [2:0] ORI_MOVING      = 3'd6;

    // Motion classes
    localparam logic [2:0] MOT_TURN_RIGHT = 3'd0;
    localparam logic [2:0] MOT_TURN_LEFT  = 3'd1;
    localparam logic [2:0] MOT_TILT_LEFT  = 3'd2;
    localparam logic [2:0] MOT_TILT_RIGHT = 3'd3;
    localparam logic [2:0] MOT_TILT_DOWN  = 3'd4;
    localparam logic [2:0] MOT_TILT_UP    = 3'd5;
    localparam logic [2:0] MOT_STABLE     = 3'd6;

    // Accel sensitivity, micro-g per LSB
    function automatic logic [SENS_W-1:0] accel_sens(input logic [1:0] sel);
        logic [SENS_W-1:0] s;
        unique case (sel)
            2'd0:    s = 17'd61;
            2'd1:    s = 17'd122;
            2'd2:    s = 17'd244;
            default: s = 17'd488;
        endcase
        return s;
    endfunction

    // Gyro sensitivity, micro-dps per LSB; unused selections read as zero
    function automatic logic [SENS_W-1:0] gyro_sens(input logic [2:0] sel);
        logic [SENS_W-1:0] s;
        unique case (sel)
            3'd0:    s = 17'd4375;
            3'd1:    s = 17'd8750;
            3'd2:    s = 17'd17500;
            3'd3:    s = 17'd35000;
            3'd4:    s = 17'd70000;
            default: s = 17'd0;
        endcase
        return s;
    endfunction

endpackage

### design/imu_orientation_motion_classifier_unit.sv
// Top level: three-stage IMU orientation / motion classifier.
`timescale 1ns / 1ps
`include "imu_orientation_motion_classifier_unit_defines.svh"
//
// Channel   | Ports                                        | Handshake
// ----------+----------------------------------------------+---------------------------
// item in   | i_command, i_sample_x/_y/_z                  | start & !busy
// item out  | o_category, o_rate_magnitude                 | o_result_valid, one cycle
// config    | i_cfg_index, i_cfg_data                      | i_cfg_we, no wait
//
// Cycles: an item may be started every cycle; busy is never raised.
// Path: an accepted item passes through the input register, the scaled-axis
//   register and the result register before the result strobe is shown.
// The three per-axis multipliers set the critical path of the middle stage.
// Reset: synchronous, active low; clears pipe valids and restores register defaults.
// Stalls: none; the receiver takes every result in the cycle it is shown.
//
module imu_orientation_motion_classifier_unit (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // item in
    input  logic                              start,
    output logic                              busy,
    input  logic                              i_command,
    input  logic signed [15:0]                i_sample_x,
    input  logic signed [15:0]                i_sample_y,
    input  logic signed [15:0]                i_sample_z,
    // config write port
    input  logic                              i_cfg_we,
    input  logic [2:0]                        i_cfg_index,
    input  logic [24:0]                       i_cfg_data,
    // item out
    output logic                              o_result_valid,
    output logic [2:0]                        o_category,
    output logic [imu_omc_pkg::MAG_W-1:0]     o_rate_magnitude
);

    localparam int VW = imu_omc_pkg::VAL_W;
    localparam int MW = imu_omc_pkg::MAG_W;
    localparam int SW = imu_omc_pkg::SENS_W;

    // ---------------- configuration registers ----------------
    logic [1:0]         r_accel_range_sel;
    logic [2:0]         r_gyro_range_sel;
    logic signed [24:0] r_ofs_x, r_ofs_y, r_ofs_z;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_accel_range_sel <= 2'd0;
            r_gyro_range_sel  <= 3'd1;
            r_ofs_x           <= '0;
            r_ofs_y           <= '0;
            r_ofs_z           <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                imu_omc_pkg::CFG_ACCEL_RANGE: r_accel_range_sel <= i_cfg_data[1:0];
                imu_omc_pkg::CFG_GYRO_RANGE:  r_gyro_range_sel  <= i_cfg_data[2:0];
                imu_omc_pkg::CFG_OFFSET_X:    r_ofs_x           <= i_cfg_data;
                imu_omc_pkg::CFG_OFFSET_Y:    r_ofs_y           <= i_cfg_data;
                imu_omc_pkg::CFG_OFFSET_Z:    r_ofs_z           <= i_cfg_data;
                default: ;  // indexes past the list are dropped
            endcase
        end
    end

    // The pipe never holds off a new item.
    assign busy = 1'b0;

    // ---------------- stage A: input register ----------------
    logic               r_a_valid;
    logic               r_a_cmd;
    logic signed [15:0] r_a_x, r_a_y, r_a_z;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else begin
            r_a_valid <= start && !busy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (start && !busy) begin
            r_a_cmd <= i_command;
            r_a_x   <= i_sample_x;
            r_a_y   <= i_sample_y;
            r_a_z   <= i_sample_z;
        end
    end

    // ---------------- stage B: scale and remove offset ----------------
    logic [SW-1:0]        w_sens;
    logic signed [VW-1:0] w_sens_ext;
    logic signed [VW-1:0] n_b_x, n_b_y, n_b_z;
    logic signed [VW-1:0] w_ofs_x, w_ofs_y, w_ofs_z;

    assign w_sens = (r_a_cmd == imu_omc_pkg::CMD_GYRO)
                  ? imu_omc_pkg::gyro_sens(r_gyro_range_sel)
                  : imu_omc_pkg::accel_sens(r_accel_range_sel);
    assign w_sens_ext = {{(VW-SW){1'b0}}, w_sens};

    // Offsets only apply to accel items.
    assign w_ofs_x = (r_a_cmd == imu_omc_pkg::CMD_ACCEL) ? {{(VW-25){r_ofs_x[24]}}, r_ofs_x} : '0;
    assign w_ofs_y = (r_a_cmd == imu_omc_pkg::CMD_ACCEL) ? {{(VW-25){r_ofs_y[24]}}, r_ofs_y} : '0;
    assign w_ofs_z = (r_a_cmd == imu_omc_pkg::CMD_ACCEL) ? {{(VW-25){r_ofs_z[24]}}, r_ofs_z} : '0;

    assign n_b_x = ({{(VW-16){r_a_x[15]}}, r_a_x} * w_sens_ext) - w_ofs_x;
    assign n_b_y = ({{(VW-16){r_a_y[15]}}, r_a_y} * w_sens_ext) - w_ofs_y;
    assign n_b_z = ({{(VW-16){r_a_z[15]}}, r_a_z} * w_sens_ext) - w_ofs_z;

    logic                 r_b_valid;
    logic                 r_b_cmd;
    logic signed [VW-1:0] r_b_x, r_b_y, r_b_z;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else begin
            r_b_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_a_valid) begin
            r_b_cmd <= r_a_cmd;
            r_b_x   <= n_b_x;
            r_b_y   <= n_b_y;
            r_b_z   <= n_b_z;
        end
    end

    // ---------------- stage C: classify ----------------
    // Gyro magnitudes stay below 2^32, so the low word of |v| is exact.
    logic [VW-1:0] w_nx, w_ny, w_nz;
    logic [MW-1:0] w_ax, w_ay, w_az;
    logic          w_z_dom, w_x_over_y;
    logic          w_x_big, w_y_big, w_z_big;
    logic [2:0]    n_cat_ori, n_cat_mot, n_category;
    logic [MW-1:0] n_mag_mot, n_rate_magnitude;

    assign w_nx = -r_b_x;
    assign w_ny = -r_b_y;
    assign w_nz = -r_b_z;
    assign w_ax = r_b_x[VW-1] ? w_nx[MW-1:0] : r_b_x[MW-1:0];
    assign w_ay = r_b_y[VW-1] ? w_ny[MW-1:0] : r_b_y[MW-1:0];
    assign w_az = r_b_z[VW-1] ? w_nz[MW-1:0] : r_b_z[MW-1:0];

    assign w_z_dom    = (w_az > w_ax) && (w_az > w_ay);
    assign w_x_over_y = (w_ax > w_ay);
    assign w_x_big    = (w_ax > imu_omc_pkg::GYRO_THRESH_UDPS);
    assign w_y_big    = (w_ay > imu_omc_pkg::GYRO_THRESH_UDPS);
    assign w_z_big    = (w_az > imu_omc_pkg::GYRO_THRESH_UDPS);

    // Orientation: z first, then x, then y; strict compares.
    always_comb begin
        priority if (r_b_z > imu_omc_pkg::ACCEL_THRESH_UG) begin
            n_cat_ori = imu_omc_pkg::ORI_SCREEN_DOWN;
        end else if (r_b_z < -imu_omc_pkg::ACCEL_THRESH_UG) begin
            n_cat_ori = imu_omc_pkg::ORI_SCREEN_UP;
        end else if (r_b_x > imu_omc_pkg::ACCEL_THRESH_UG) begin
            n_cat_ori = imu_omc_pkg::ORI_TOP_DOWN;
        end else if (r_b_x < -imu_omc_pkg::ACCEL_THRESH_UG) begin
            n_cat_ori = imu_omc_pkg::ORI_BOTTOM_DOWN;
        end else if (r_b_y > imu_omc_pkg::ACCEL_THRESH_UG) begin
            n_cat_ori = imu_omc_pkg::ORI_RIGHT_DOWN;
        end else if (r_b_y < -imu_omc_pkg::ACCEL_THRESH_UG) begin
            n_cat_ori = imu_omc_pkg::ORI_LEFT_DOWN;
        end else begin
            n_cat_ori = imu_omc_pkg::ORI_MOVING;
        end
    end

    // Motion: dominant z, else the larger of x and y (ties go to y).
    // A dominant z under threshold falls through to the x/y test.
    always_comb begin
        priority if (w_z_dom && w_z_big) begin
            n_cat_mot = r_b_z[VW-1] ? imu_omc_pkg::MOT_TURN_LEFT : imu_omc_pkg::MOT_TURN_RIGHT;
            n_mag_mot = w_az;
        end else if (w_x_over_y && w_x_big) begin
            n_cat_mot = r_b_x[VW-1] ? imu_omc_pkg::MOT_TILT_RIGHT : imu_omc_pkg::MOT_TILT_LEFT;
            n_mag_mot = w_ax;
        end else if (!w_x_over_y && w_y_big) begin
            n_cat_mot = r_b_y[VW-1] ? imu_omc_pkg::MOT_TILT_UP : imu_omc_pkg::MOT_TILT_DOWN;
            n_mag_mot = w_ay;
        end else begin
            n_cat_mot = imu_omc_pkg::MOT_STABLE;
            n_mag_mot = '0;
        end
    end

    assign n_category       = (r_b_cmd == imu_omc_pkg::CMD_GYRO) ? n_cat_mot : n_cat_ori;
    assign n_rate_magnitude = (r_b_cmd == imu_omc_pkg::CMD_GYRO) ? n_mag_mot : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_result_valid <= 1'b0;
        end else begin
            o_result_valid <= r_b_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_b_valid) begin
            o_category       <= n_category;
            o_rate_magnitude <= n_rate_magnitude;
        end
    end

    // ---------------- assertions ----------------
    // Strobe is set by the result register, after the input and scaled-axis registers.
    `IMU_OMC_ASSERT_DLY3(a_latency, i_clk, i_rst_n, start && !busy, o_result_valid,
        "accepted item did not produce a result strobe two edges later")
    `IMU_OMC_ASSERT_IMPL(a_stable_zero, i_clk, i_rst_n,
        o_result_valid && (o_category == imu_omc_pkg::MOT_STABLE), o_rate_magnitude == '0,
        "stable or moving result carries a non-zero magnitude")
    `IMU_OMC_ASSERT_IMPL(a_mag_over_thresh, i_clk, i_rst_n,
        o_result_valid && (o_rate_magnitude != '0),
        o_rate_magnitude > imu_omc_pkg::GYRO_THRESH_UDPS,
        "reported rate magnitude not above the motion threshold")

endmodule
